>>> rtl/mctb_pkg.sv
// Shared types and constants for the multi-channel timer bank.
// Used by mctb_ctrl, mctb_datapath and multi_channel_soft_timer_bank.
package mctb_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int COUNT_W  = 32;
  localparam int INC_W    = 16;
  localparam int MASK_W   = 8;

  // Command codes of a request.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  localparam logic [INC_W-1:0] INC_RESET = 16'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ID_W-1:0]    timer_id;
    logic               one_shot;
    logic [COUNT_W-1:0] period;
  } mctb_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic              bad_id;
  } mctb_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_APPLY,
    ST_FINISH
  } mctb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted request, clear sweep index and result
    logic step;      // service the channel under the sweep index
    logic apply;     // carry out a start or stop
    logic load_res;  // move the finished result into the output register
  } mctb_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // sweep index points at the last channel
    logic out_free;  // output register can take a result this cycle
  } mctb_sts_t;

endpackage

>>> rtl/mctb_ctrl.sv
// Controller state machine of the timer bank.
// Depends on mctb_pkg for the state, command and status types.
module mctb_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic [mctb_pkg::CMD_W-1:0]       req_command,
  output logic                             req_stall,
  input  mctb_pkg::mctb_sts_t              sts,
  output mctb_pkg::mctb_ctl_t              ctl
);

  mctb_pkg::mctb_state_t state;
  mctb_pkg::mctb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mctb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mctb_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_command == mctb_pkg::CMD_TICK) begin
            state_next = mctb_pkg::ST_SWEEP;
          end else begin
            state_next = mctb_pkg::ST_APPLY;
          end
        end
      end
      mctb_pkg::ST_SWEEP: begin
        if (sts.last) begin
          state_next = mctb_pkg::ST_FINISH;
        end
      end
      mctb_pkg::ST_APPLY: begin
        state_next = mctb_pkg::ST_FINISH;
      end
      mctb_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          state_next = mctb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mctb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall    = 1'b1;
    ctl          = '0;
    unique case (state)
      mctb_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        ctl.load  = req_valid;
      end
      mctb_pkg::ST_SWEEP: begin
        ctl.step = 1'b1;
      end
      mctb_pkg::ST_APPLY: begin
        ctl.apply = 1'b1;
      end
      mctb_pkg::ST_FINISH: begin
        ctl.load_res = sts.out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // A sweep that reaches the last channel always hands over to the finish step.
  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == mctb_pkg::ST_SWEEP && sts.last) |=> (state == mctb_pkg::ST_FINISH))
    else $error("sweep did not end after the last channel");

endmodule

>>> rtl/mctb_datapath.sv
// Datapath of the timer bank: channel state, tick sweep, start/stop and result register.
// Depends on mctb_pkg for the request, result, command and status types.
module mctb_datapath #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mctb_pkg::mctb_req_t           req,
  input  logic                          cfg_valid,
  input  logic [mctb_pkg::INC_W-1:0]    cfg_data,
  input  mctb_pkg::mctb_ctl_t           ctl,
  output mctb_pkg::mctb_sts_t           sts,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mctb_pkg::mctb_rsp_t           rsp
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW    = mctb_pkg::COUNT_W;

  mctb_pkg::mctb_req_t             cmd_q;
  logic [IDX_W-1:0]                idx;
  logic [mctb_pkg::INC_W-1:0]      tick_inc;
  logic [mctb_pkg::MASK_W-1:0]     mask_q;
  logic                            bad_q;

  logic                            active [NUM_TIMERS];
  logic                            once   [NUM_TIMERS];
  logic [CW-1:0]                   elapsed[NUM_TIMERS];
  logic [CW-1:0]                   thresh [NUM_TIMERS];

  logic [CW:0]                     sum;
  logic [CW-1:0]                   sat;
  logic                            hit;
  logic                            in_range;
  logic [IDX_W-1:0]                id_idx;
  logic [mctb_pkg::MASK_W-1:0]     mask_bit;
  logic                            is_start;
  logic                            is_stop;

  assign sum      = {1'b0, elapsed[idx]} + {{(CW + 1 - mctb_pkg::INC_W){1'b0}}, tick_inc};
  assign sat      = sum[CW] ? '1 : sum[CW-1:0];
  assign hit      = (sat >= thresh[idx]);
  assign in_range = ({1'b0, cmd_q.timer_id} < 5'(NUM_TIMERS));
  assign id_idx   = IDX_W'(cmd_q.timer_id);
  assign is_start = (cmd_q.command == mctb_pkg::CMD_START);
  assign is_stop  = (cmd_q.command == mctb_pkg::CMD_STOP);
  assign mask_bit = (32'(idx) < 32'(mctb_pkg::MASK_W))
                    ? (mctb_pkg::MASK_W'(1) << idx) : '0;

  assign sts.last     = (idx == IDX_W'(NUM_TIMERS - 1));
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_inc <= mctb_pkg::INC_RESET;
    end else if (cfg_valid) begin
      tick_inc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= req;
      idx   <= '0;
    end else if (ctl.step && !sts.last) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_q <= '0;
      bad_q  <= 1'b0;
    end else if (ctl.load) begin
      mask_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      if (ctl.step && active[idx] && hit) begin
        mask_q <= mask_q | mask_bit;
      end
      if (ctl.apply) begin
        bad_q <= (is_start || is_stop) && !in_range;
      end
    end
  end

  // Only the active flags need a reset; the other fields matter once a start wrote them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        active[k] <= 1'b0;
      end
    end else if (ctl.step) begin
      if (active[idx] && hit && once[idx]) begin
        active[idx] <= 1'b0;
      end
    end else if (ctl.apply && in_range) begin
      if (is_start) begin
        active[id_idx] <= 1'b1;
      end else if (is_stop) begin
        active[id_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (active[idx]) begin
        elapsed[idx] <= hit ? '0 : sat;
      end
    end else if (ctl.apply && in_range && is_start) begin
      elapsed[id_idx] <= '0;
      thresh[id_idx]  <= cmd_q.period;
      once[id_idx]    <= cmd_q.one_shot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_res) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_res) begin
      rsp.expired_mask <= mask_q;
      rsp.bad_id       <= bad_q;
    end
  end

  a_step_is_tick: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> (cmd_q.command == mctb_pkg::CMD_TICK))
    else $error("channel sweep running for a request that is not a tick");

  a_apply_not_tick: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |-> (cmd_q.command != mctb_pkg::CMD_TICK))
    else $error("start/stop step running for a tick");

  a_bad_has_no_mask: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bad_id) |-> (rsp.expired_mask == '0))
    else $error("result flags a bad id and an expiry at once");

endmodule

>>> rtl/multi_channel_soft_timer_bank.sv
// Top level of the multi-channel timer bank.
// Depends on mctb_pkg, mctb_ctrl and mctb_datapath.
//
// A bank of NUM_TIMERS timer channels driven by requests. A tick request sweeps the
// channels one per clock cycle through a single saturating adder and comparator, and
// no new request is taken until its result has gone into the output register; start,
// stop and unused codes go through the apply step instead. The result for every request
// is written into an output register, and the next request can be taken while that
// result still waits downstream; a new result waits only if the previous one has not
// been taken yet. Start arms a channel with a period and a mode, stop disarms it, and
// a start or stop that names a channel at or beyond NUM_TIMERS changes nothing and
// answers with bad_id set. Each tick adds the tick_increment register to every armed
// channel's count (saturating at all ones); a count that reaches its period is cleared,
// a one-shot channel disarms, and the channel's bit is set in expired_mask (channels
// eight and up have no bit). The tick_increment register is written through the cfg
// port, which is always ready; write it only while no request is in flight.
module multi_channel_soft_timer_bank #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  mctb_pkg::mctb_req_t           req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mctb_pkg::mctb_rsp_t           rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mctb_pkg::INC_W-1:0]    cfg_data
);

  mctb_pkg::mctb_ctl_t ctl;
  mctb_pkg::mctb_sts_t sts;

  // The increment register is a plain flop, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller sequences each request: capture, sweep or apply, then hand off.
  mctb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_stall   (req_stall),
    .sts         (sts),
    .ctl         (ctl)
  );

  // The datapath holds all channel state and the output register.
  mctb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
